/* rtl/core/lli_pkg.sv */
// Shared types and constants for the line intersection unit.
`default_nettype none
package lli_pkg;
  // Fixed field widths of the default Q16.16 build.
  localparam int unsigned CoordW = 32;
  localparam int unsigned InDataW = 8 * CoordW;
  localparam int unsigned OutDataW = 2 * CoordW;
  localparam int unsigned OutUserW = 2;

  // Bit positions inside the result tuser.
  localparam int unsigned UserParallel = 0;
  localparam int unsigned UserSat = 1;

  typedef struct packed {
    logic sat;
    logic par;
  } flags_t;
endpackage
`default_nettype wire

/* rtl/core/lli_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with stall.
`default_nettype none
module lli_div #(
  parameter int unsigned NumW = 8,
  parameter int unsigned DenW = 8,
  parameter int unsigned TagW = 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  input  wire logic [TagW-1:0] tag_i,
  output logic                 valid_o,
  output logic [NumW-1:0]      quo_o,
  output logic [TagW-1:0]      tag_o
);
  localparam int unsigned RemW = DenW + 1;

  logic [NumW:1]           vld_q;
  logic [NumW-1:0]         num_q [1:NumW];
  logic [RemW-1:0]         rem_q [1:NumW];
  logic [DenW-1:0]         den_q [1:NumW];
  logic [TagW-1:0]         tag_q [1:NumW];

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic            vld_c;
    logic [NumW-1:0] num_c;
    logic [RemW-1:0] rem_c;
    logic [DenW-1:0] den_c;
    logic [TagW-1:0] tag_c;
    logic [RemW-1:0] sh;
    logic [RemW:0]   diff;
    logic [NumW-1:0] num_d;
    logic [RemW-1:0] rem_d;
    if (s == 0) begin : g_head
      assign vld_c = valid_i;
      assign num_c = num_i;
      assign rem_c = '0;
      assign den_c = den_i;
      assign tag_c = tag_i;
    end else begin : g_body
      assign vld_c = vld_q[s];
      assign num_c = num_q[s];
      assign rem_c = rem_q[s];
      assign den_c = den_q[s];
      assign tag_c = tag_q[s];
    end
    always_comb begin
      sh = {rem_c[RemW-2:0], num_c[NumW-1]};
      diff = {1'b0, sh} - {2'b00, den_c};
      num_d = {num_c[NumW-2:0], ~diff[RemW]};
      rem_d = diff[RemW] ? sh : diff[RemW-1:0];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_c;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1] <= num_d;
        rem_q[s+1] <= rem_d;
        den_q[s+1] <= den_c;
        tag_q[s+1] <= tag_c;
      end
    end
  end

  assign valid_o = vld_q[NumW];
  assign quo_o = num_q[NumW];
  assign tag_o = tag_q[NumW];
endmodule
`default_nettype wire

/* rtl/core/line_line_intersection_2d_unit.sv */
// Line-line intersection by Cramer's rule, fully pipelined, stream ports.
// Throughput: one word per cycle while the output buffer has room; the bit-per-stage divider sets the depth.
// A stall on the output holds every stage once the output buffer is full.
// Reset clears all valid bits asynchronously; payload registers are not reset.
// The two-deep output skid buffer lets input flow while a result waits.
`default_nettype none
module line_line_intersection_2d_unit #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // ax, ay, bx, by, cx, cy, dx, dy from the lowest bit up
  input  wire logic [8*COORD_WIDTH-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // cross_x, cross_y from the lowest bit up
  output logic [2*COORD_WIDTH-1:0]     m_axis_tdata,
  // lines_parallel, saturated from the lowest bit up
  output logic [lli_pkg::OutUserW-1:0] m_axis_tuser
);
  import lli_pkg::*;

  localparam int unsigned W = COORD_WIDTH;
  localparam int unsigned DW = W + 1;        // differences
  localparam int unsigned PW = 2 * DW;       // products
  localparam int unsigned CW = PW + 1;       // c and det
  localparam int unsigned NW = DW + CW + 1;  // x/y numerators (with sign)
  localparam int unsigned MNW = NW - 1;      // numerator magnitude
  localparam int unsigned MDW = CW;          // det magnitude
  localparam int unsigned LoW = DW + 1;      // low slice of c, unsigned
  localparam int unsigned LoPW = DW + LoW + 1;
  localparam int unsigned FrUnused = FRAC_BITS;
  localparam logic [W-1:0] MaxPos = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MinNeg = {1'b1, {(W-1){1'b0}}};

  logic en;
  logic out_full_q;
  logic [1:0] skid_cnt_q;

  // Stage 1: differences.
  logic v1_q;
  logic signed [DW-1:0] a1_q, b1_q, a2_q, b2_q;
  logic signed [W-1:0] ax1_q, ay1_q, cx1_q, cy1_q;
  // Stage 2: products for c and det.
  logic v2_q;
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  logic signed [DW-1:0] a1_2q, b1_2q, a2_2q, b2_2q;
  // Stage 3: c1, c2, det.
  logic v3_q;
  logic signed [CW-1:0] c1_q, c2_q, det_q;
  logic signed [DW-1:0] a1_3q, b1_3q, a2_3q, b2_3q;
  // Stage 4a: partial products on the low and high halves of c.
  logic v4a_q;
  logic signed [LoPW-1:0] m1l_q, m2l_q, m3l_q, m4l_q;
  logic signed [PW-1:0] m1h_q, m2h_q, m3h_q, m4h_q;
  logic signed [CW-1:0] det_4aq;
  // Stage 4: numerator products.
  logic v4_q;
  logic signed [NW-2:0] m1_q, m2_q, m3_q, m4_q;
  logic signed [CW-1:0] det_4q;
  // Stage 5: numerators.
  logic v5_q;
  logic signed [NW-1:0] nx_q, ny_q;
  logic signed [CW-1:0] det_5q;
  // Stage 6: magnitudes and signs.
  logic v6_q;
  logic [MNW-1:0] mx_q, my_q;
  logic [MDW-1:0] md_q;
  logic negx_q, negy_q, par_q;

  wire [W-1:0] in_f [8];
  for (genvar k = 0; k < 8; k++) begin : g_in
    assign in_f[k] = s_axis_tdata[k*W +: W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4a_q <= 1'b0;
      v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid; v2_q <= v1_q; v3_q <= v2_q; v4a_q <= v3_q;
      v4_q <= v4a_q; v5_q <= v4_q; v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q <= DW'($signed(in_f[3])) - DW'($signed(in_f[1]));
      b1_q <= DW'($signed(in_f[0])) - DW'($signed(in_f[2]));
      a2_q <= DW'($signed(in_f[7])) - DW'($signed(in_f[5]));
      b2_q <= DW'($signed(in_f[4])) - DW'($signed(in_f[6]));
      ax1_q <= in_f[0]; ay1_q <= in_f[1]; cx1_q <= in_f[4]; cy1_q <= in_f[5];

      p1_q <= PW'(a1_q * DW'(ax1_q));
      p2_q <= PW'(b1_q * DW'(ay1_q));
      p3_q <= PW'(a2_q * DW'(cx1_q));
      p4_q <= PW'(b2_q * DW'(cy1_q));
      p5_q <= PW'(a1_q * b2_q);
      p6_q <= PW'(a2_q * b1_q);
      a1_2q <= a1_q; b1_2q <= b1_q; a2_2q <= a2_q; b2_2q <= b2_q;

      c1_q <= CW'(p1_q) + CW'(p2_q);
      c2_q <= CW'(p3_q) + CW'(p4_q);
      det_q <= CW'(p5_q) - CW'(p6_q);
      a1_3q <= a1_2q; b1_3q <= b1_2q; a2_3q <= a2_2q; b2_3q <= b2_2q;

      // c is split into a signed high half and an unsigned low half.
      m1l_q <= LoPW'(b2_3q * LoPW'($signed({1'b0, c1_q[LoW-1:0]})));
      m2l_q <= LoPW'(b1_3q * LoPW'($signed({1'b0, c2_q[LoW-1:0]})));
      m3l_q <= LoPW'(a1_3q * LoPW'($signed({1'b0, c2_q[LoW-1:0]})));
      m4l_q <= LoPW'(a2_3q * LoPW'($signed({1'b0, c1_q[LoW-1:0]})));
      m1h_q <= PW'(b2_3q * PW'($signed(c1_q[CW-1:LoW])));
      m2h_q <= PW'(b1_3q * PW'($signed(c2_q[CW-1:LoW])));
      m3h_q <= PW'(a1_3q * PW'($signed(c2_q[CW-1:LoW])));
      m4h_q <= PW'(a2_3q * PW'($signed(c1_q[CW-1:LoW])));
      det_4aq <= det_q;

      m1_q <= ((NW-1)'(m1h_q) <<< LoW) + (NW-1)'(m1l_q);
      m2_q <= ((NW-1)'(m2h_q) <<< LoW) + (NW-1)'(m2l_q);
      m3_q <= ((NW-1)'(m3h_q) <<< LoW) + (NW-1)'(m3l_q);
      m4_q <= ((NW-1)'(m4h_q) <<< LoW) + (NW-1)'(m4l_q);
      det_4q <= det_4aq;

      nx_q <= NW'(m1_q) - NW'(m2_q);
      ny_q <= NW'(m3_q) - NW'(m4_q);
      det_5q <= det_4q;

      negx_q <= nx_q[NW-1] ^ det_5q[CW-1];
      negy_q <= ny_q[NW-1] ^ det_5q[CW-1];
      mx_q <= MNW'(nx_q[NW-1] ? -nx_q : nx_q);
      my_q <= MNW'(ny_q[NW-1] ? -ny_q : ny_q);
      md_q <= det_5q[CW-1] ? MDW'(-det_5q) : MDW'(det_5q);
      par_q <= (det_5q == '0);
    end
  end

  // The zero divisor of a parallel case yields all ones; it is replaced later.
  logic dvx, dvy;
  logic [MNW-1:0] qx, qy;
  logic [1:0] tx, ty;

  lli_div #(.NumW(MNW), .DenW(MDW), .TagW(2)) u_divx (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q), .num_i(mx_q), .den_i(md_q),
    .tag_i({par_q, negx_q}), .valid_o(dvx), .quo_o(qx), .tag_o(tx)
  );
  lli_div #(.NumW(MNW), .DenW(MDW), .TagW(2)) u_divy (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v6_q), .num_i(my_q), .den_i(md_q),
    .tag_i({par_q, negy_q}), .valid_o(dvy), .quo_o(qy), .tag_o(ty)
  );

  // Stage 7: clamp and sign.
  logic v7_q;
  logic [W-1:0] ox_q, oy_q;
  flags_t fl_q;
  logic ovx, ovy;
  logic [W-1:0] rx, ry;

  always_comb begin
    ovx = tx[0] ? (qx > MNW'(MinNeg)) : (qx > MNW'(MaxPos));
    ovy = ty[0] ? (qy > MNW'(MinNeg)) : (qy > MNW'(MaxPos));
    rx = ovx ? (tx[0] ? MinNeg : MaxPos) : (tx[0] ? -qx[W-1:0] : qx[W-1:0]);
    ry = ovy ? (ty[0] ? MinNeg : MaxPos) : (ty[0] ? -qy[W-1:0] : qy[W-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en) begin
      v7_q <= dvx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q <= tx[1] ? MaxPos : rx;
      oy_q <= tx[1] ? MaxPos : ry;
      fl_q.par <= tx[1];
      fl_q.sat <= !tx[1] && (ovx || ovy);
    end
  end

  // Two-entry skid buffer at the output; the pipe advances while it has room.
  localparam int unsigned EntW = 2 * W + OutUserW;
  logic [EntW-1:0] buf_q [2];
  logic rd_ptr_q, wr_ptr_q;
  logic push, pop;

  assign push = en && v7_q;
  assign pop = m_axis_tvalid && m_axis_tready;
  assign en = (skid_cnt_q != 2'd2);
  assign s_axis_tready = en;
  assign m_axis_tvalid = (skid_cnt_q != 2'd0);
  assign out_full_q = (skid_cnt_q == 2'd2);
  assign {m_axis_tuser, m_axis_tdata} = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_cnt_q <= 2'd0;
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
    end else begin
      skid_cnt_q <= skid_cnt_q + 2'(push) - 2'(pop);
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= {fl_q.sat, fl_q.par, oy_q, ox_q};
    end
  end

  wire unused_ok = (FrUnused >= 0) && dvy;

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni) dvx == dvy)
    else $error("divider lanes out of step");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && out_full_q && !pop))
    else $error("skid buffer overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[UserParallel] && m_axis_tuser[UserSat]))
    else $error("parallel result marked saturated");
  assert property (@(posedge clk_i) disable iff (!rst_ni) unused_ok || !dvx)
    else $error("divider lane y idle while x valid");
`endif
endmodule
`default_nettype wire
